// ===== hdl/mlqs_pkg.sv =====
`timescale 1ns / 1ps
package mlqs_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam logic [7:0] PRIO_MAX = 8'd149;
	localparam logic [7:0] L1_LOW = 8'd100;
	localparam logic [7:0] L2_LOW = 8'd50;
	localparam logic [15:0] PERIOD_RST = 16'd1500;
	localparam logic [7:0] STEP_RST = 8'd10;
	localparam logic [15:0] WAIT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_TICK = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		REG_PERIOD = 1'b0,
		REG_STEP = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_AGE,
		ST_PLACE,
		ST_DONE
	} state_t;

	// contents of one slot
	typedef struct packed {
		logic valid;
		logic [7:0] id;
		logic [7:0] prio;
		logic [15:0] burst;
		logic [15:0] wait_cnt;
		logic [1:0] level;
		logic [15:0] arrival;
		logic aged;
	} slot_t;

	// candidate carried along the chain during a scan
	typedef struct packed {
		logic found;
		logic [1:0] level;
		logic [7:0] id;
		logic [7:0] prio;
		logic [15:0] burst;
		logic [15:0] age;
	} cand_t;

	// command broadcast to every cell
	typedef struct packed {
		logic tick;
		logic clr_aged;
		logic [15:0] period;
		logic [7:0] step;
		logic [15:0] arrival;
	} cell_cmd_t;

	function automatic logic [1:0] level_of(input logic [7:0] p);
		if (p >= L1_LOW) return 2'd1;
		if (p >= L2_LOW) return 2'd2;
		return 2'd3;
	endfunction

	function automatic logic [7:0] sat_add(input logic [7:0] p, input logic [7:0] s);
		logic [8:0] n;
		n = {1'b0, p} + {1'b0, s};
		return (n > {1'b0, PRIO_MAX}) ? PRIO_MAX : n[7:0];
	endfunction

	// a served before b, same level
	function automatic logic better(input cand_t a, input cand_t b);
		if (a.level == 2'd1) begin
			if (a.burst != b.burst) return a.burst < b.burst;
			if (a.id != b.id) return a.id < b.id;
		end else if (a.level == 2'd2) begin
			if (a.prio != b.prio) return a.prio > b.prio;
			if (a.id != b.id) return a.id < b.id;
		end
		return a.age > b.age;
	endfunction

endpackage

// ===== hdl/multilevel_queue_scheduler_aging_top.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// input   | in        | in_valid/in_ready  | op thread_id priority_req burst_time current_id
// result  | out       | out_valid/out_ready| got_thread out_thread_id out_level
//         |           |                    | yield_request table_full aged_count
// config  | in        | cfg_we             | cfg_index cfg_data
// One item at a time. Enqueue: one scan of all slots (one slot scanned a cycle),
// then placement. Dequeue: one scan per level searched, up to three levels.
// Tick: an ageing step, then one scan per reinsertion plus two empty scans.
// No-op: result on the next cycle. Reset clears valid bits, arrival counter and
// configuration registers; no clearing pass. A held result stalls intake until taken.
module multilevel_queue_scheduler_aging_top
	import mlqs_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] op,
	input logic [7:0] thread_id,
	input logic [7:0] priority_req,
	input logic [15:0] burst_time,
	input logic [7:0] current_id,
	output logic out_valid,
	input logic out_ready,
	output logic got_thread,
	output logic [7:0] out_thread_id,
	output logic [1:0] out_level,
	output logic yield_request,
	output logic table_full,
	output logic [6:0] aged_count,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data
);

	localparam int IW = $clog2(ENTRIES);

	state_t state_q, state_d;
	logic [15:0] period_q;
	logic [7:0] step_q;
	logic [15:0] arr_q;
	op_t op_q;
	logic [7:0] id_q, prio_q, cur_q;
	logic [15:0] burst_q;
	logic [IW:0] cnt_q;
	logic [1:0] lvl_q;
	logic free_found_q, dup_q;
	logic [IW-1:0] free_idx_q;
	logic yld_q, full_q, got_q;
	logic [7:0] oid_q;
	logic [1:0] olv_q;
	logic [6:0] aged_n_q;
	logic out_valid_q;

	slot_t slots [ENTRIES];
	logic [ENTRIES-1:0] wr_en;
	slot_t wr_data;
	cell_cmd_t cmd;
	slot_t cur_slot;
	logic [IW-1:0] sidx;
	logic scan_start;
	cand_t best;
	logic [IW-1:0] best_idx;
	slot_t bslot;
	logic [7:0] np;
	logic [1:0] nl;
	logic id_hit;
	logic [6:0] aged_cnt_now;
	logic [ENTRIES-1:0] will_age;
	logic [ENTRIES-1:0] cur_l1;
	logic [ENTRIES-1:0] dup_l1;
	logic dup_q_tick;

	// slot array
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		mlqs_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.wr_en(wr_en[g]), .wr_data(wr_data), .slot(slots[g])
		);
	end

	assign sidx = cnt_q[IW-1:0];
	assign cur_slot = slots[sidx];
	assign bslot = slots[best_idx];
	assign np = sat_add(bslot.prio, step_q);
	assign nl = level_of(np);

	mlqs_scan #(.IW(IW)) u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start), .lvl(lvl_q),
		.aged_only(op_q == OP_TICK), .arrival(arr_q), .slot(cur_slot),
		.idx(sidx), .best(best), .best_idx(best_idx)
	);

	// duplicate check id for the current scan position
	assign id_hit = cur_slot.valid && cur_slot.level == 2'd1 && cur_slot.id == id_q;

	// aged count at the tick: slots that cross the period this cycle
	for (genvar g = 0; g < ENTRIES; g++) begin : g_age
		logic [15:0] wi;
		assign wi = (slots[g].wait_cnt == WAIT_MAX) ? WAIT_MAX : slots[g].wait_cnt + 16'd1;
		assign will_age[g] = slots[g].valid && wi >= period_q &&
			(slots[g].level != 2'd3 || slots[g].id > 8'd1);
	end
	assign aged_cnt_now = 7'($countones(will_age));

	// level-one presence of the running thread for the yield check
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cur
		assign cur_l1[g] = slots[g].valid && slots[g].level == 2'd1 &&
			slots[g].id == cur_q;
	end

	// duplicate check of the aged thread's id against level one
	for (genvar g = 0; g < ENTRIES; g++) begin : g_dup
		assign dup_l1[g] = (IW'(g) != best_idx) && slots[g].valid &&
			slots[g].level == 2'd1 && slots[g].id == bslot.id;
	end
	assign dup_q_tick = |dup_l1;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign got_thread = got_q;
	assign out_thread_id = oid_q;
	assign out_level = olv_q;
	assign yield_request = yld_q;
	assign table_full = full_q;
	assign aged_count = aged_n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state and slot writes
	always_comb begin
		state_d = state_q;
		wr_en = '0;
		wr_data = bslot;
		cmd.tick = 1'b0;
		cmd.clr_aged = 1'b0;
		cmd.period = period_q;
		cmd.step = step_q;
		cmd.arrival = arr_q;
		scan_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				scan_start = 1'b1;
				if (in_valid) begin
					priority case (op_t'(op))
						OP_TICK: state_d = ST_AGE;
						OP_NOP: state_d = ST_DONE;
						default: state_d = ST_SCAN;
					endcase
				end
			end
			ST_AGE: begin
				cmd.tick = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q == ENTRIES[IW:0]) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				scan_start = 1'b1;
				state_d = ST_SCAN;
				if (op_q == OP_ENQ) begin
					wr_data.valid = 1'b1;
					wr_data.id = id_q;
					wr_data.prio = prio_q;
					wr_data.burst = burst_q;
					wr_data.wait_cnt = '0;
					wr_data.level = level_of(prio_q);
					wr_data.arrival = arr_q;
					wr_data.aged = 1'b0;
					if (!dup_q && free_found_q) wr_en[free_idx_q] = 1'b1;
					state_d = ST_DONE;
				end else if (op_q == OP_DEQ) begin
					wr_data.valid = 1'b0;
					if (best.found) begin
						wr_en[best_idx] = 1'b1;
						state_d = ST_DONE;
					end else if (lvl_q == 2'd3) begin
						state_d = ST_DONE;
					end
				end else begin
					wr_data.aged = 1'b0;
					wr_data.prio = np;
					wr_data.wait_cnt = '0;
					wr_data.level = nl;
					wr_data.arrival = arr_q;
					if (best.found) begin
						wr_en[best_idx] = 1'b1;
						if (nl == 2'd1 && dup_q_tick) wr_data.valid = 1'b0;
					end else if (lvl_q == 2'd3) begin
						cmd.clr_aged = 1'b1;
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			step_q <= STEP_RST;
			arr_q <= '0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			op_q <= OP_NOP;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_PERIOD: period_q <= cfg_data;
					REG_STEP: step_q <= cfg_data[7:0];
				endcase
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						op_q <= op_t'(op);
						id_q <= thread_id;
						prio_q <= (priority_req > PRIO_MAX) ? PRIO_MAX : priority_req;
						burst_q <= burst_time;
						cur_q <= current_id;
						lvl_q <= (op_t'(op) == OP_TICK) ? 2'd2 : 2'd1;
						free_found_q <= 1'b0;
						dup_q <= 1'b0;
						yld_q <= 1'b0;
						full_q <= 1'b0;
						got_q <= 1'b0;
						oid_q <= '0;
						olv_q <= '0;
						aged_n_q <= '0;
						// no-op: all-zero result straight away
						if (op_t'(op) == OP_NOP) out_valid_q <= 1'b1;
					end
				end
				ST_AGE: begin
					aged_n_q <= aged_cnt_now;
				end
				ST_SCAN: begin
					if (cnt_q != ENTRIES[IW:0]) begin
						cnt_q <= cnt_q + 1'b1;
						if (op_q == OP_ENQ) begin
							if (!cur_slot.valid && !free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q <= sidx;
							end
							if (level_of(prio_q) == 2'd1 && id_hit) dup_q <= 1'b1;
						end
					end
				end
				ST_PLACE: begin
					cnt_q <= '0;
					dup_q <= 1'b0;
					if (op_q == OP_ENQ) begin
						out_valid_q <= 1'b1;
						if (!dup_q) begin
							if (!free_found_q) begin
								full_q <= 1'b1;
							end else begin
								arr_q <= arr_q + 16'd1;
								if (level_of(prio_q) == 2'd1 && cur_q > 8'd1 &&
										cur_q != id_q && !(|cur_l1))
									yld_q <= 1'b1;
							end
						end
					end else if (op_q == OP_DEQ) begin
						if (best.found) begin
							got_q <= 1'b1;
							oid_q <= best.id;
							olv_q <= lvl_q;
							out_valid_q <= 1'b1;
						end else if (lvl_q == 2'd3) begin
							out_valid_q <= 1'b1;
						end else begin
							lvl_q <= lvl_q + 2'd1;
						end
					end else begin
						if (best.found) begin
							if (!(nl == 2'd1 && dup_q_tick)) begin
								arr_q <= arr_q + 16'd1;
								if (nl == 2'd1 && cur_q > 8'd1 && !(|cur_l1) &&
										bslot.id != cur_q)
									yld_q <= 1'b1;
							end
						end else if (lvl_q == 2'd3) begin
							out_valid_q <= 1'b1;
						end else begin
							lvl_q <= lvl_q + 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_thread_id))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (got_thread == (out_level != 2'd0)))
		else $error("level and got flag disagree");

endmodule

// ===== hdl/mlqs_cell.sv =====
`timescale 1ns / 1ps
module mlqs_cell
	import mlqs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cell_cmd_t cmd,
	input logic wr_en,
	input slot_t wr_data,
	output slot_t slot
);

	slot_t slot_q;
	logic [15:0] w_inc;
	logic age_now;

	assign slot = slot_q;
	assign w_inc = (slot_q.wait_cnt == WAIT_MAX) ? WAIT_MAX : slot_q.wait_cnt + 16'd1;
	assign age_now = (w_inc >= cmd.period) && (slot_q.level != 2'd3 || slot_q.id > 8'd1);

	// slot register: tick ages in place, clear command drops the aged flag, write port replaces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q.valid <= 1'b0;
			slot_q.aged <= 1'b0;
		end else if (wr_en) begin
			slot_q <= wr_data;
		end else if (cmd.tick && slot_q.valid) begin
			if (age_now) begin
				slot_q.wait_cnt <= '0;
				if (slot_q.level == 2'd1) slot_q.prio <= sat_add(slot_q.prio, cmd.step);
				else slot_q.aged <= 1'b1;
			end else begin
				slot_q.wait_cnt <= w_inc;
			end
		end else if (cmd.clr_aged) begin
			slot_q.aged <= 1'b0;
		end
	end

endmodule

// ===== hdl/mlqs_scan.sv =====
`timescale 1ns / 1ps
module mlqs_scan
	import mlqs_pkg::*;
#(
	parameter int IW = 4
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] lvl,
	input logic aged_only,
	input logic [15:0] arrival,
	input slot_t slot,
	input logic [IW-1:0] idx,
	output cand_t best,
	output logic [IW-1:0] best_idx
);

	cand_t best_q;
	logic [IW-1:0] best_idx_q;
	cand_t c;
	logic hit;
	logic [15:0] age;

	assign age = arrival - slot.arrival;
	assign c = {1'b1, slot.level, slot.id, slot.prio, slot.burst, age};
	assign hit = slot.valid && slot.level == lvl && (!aged_only || slot.aged);

	// running best over one slot a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q.found <= 1'b0;
		end else if (start) begin
			best_q.found <= 1'b0;
		end else if (hit && (!best_q.found || better(c, best_q))) begin
			best_q <= c;
			best_idx_q <= idx;
		end
	end

	assign best = best_q;
	assign best_idx = best_idx_q;

endmodule
